@@ rtl/core/hcb_pkg.sv @@
package hcb_pkg;

  // Command codes carried in the input beat.
  localparam logic [1:0] CMD_COUNT  = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_ENCODE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Status codes returned with every result beat.
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_ABSENT    = 3'd1;
  localparam logic [2:0] STS_TOO_LONG  = 3'd2;
  localparam logic [2:0] STS_SATURATED = 3'd3;
  localparam logic [2:0] STS_NOT_BUILT = 3'd4;

  localparam int DISTINCT_W = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT,
    ST_ENC,
    ST_LEAF,
    ST_MTOP,
    ST_SCAN,
    ST_MW0,
    ST_MW1,
    ST_MW2,
    ST_CODE,
    ST_CFET,
    ST_WREQ,
    ST_WDAT,
    ST_RESP
  } hcb_state_t;

endpackage

@@ rtl/core/hcb_min2.sv @@
// Tracks the lowest and second lowest frequency over a stream of nodes.
// Strict compares keep the first sampled index among equal frequencies.
module hcb_min2
  import hcb_pkg::*;
#(
  parameter int FW = 24,
  parameter int IW = 9
) (
  input  logic          clk,
  input  logic          clr,
  input  logic          smp,
  input  logic [FW-1:0] smp_freq,
  input  logic [IW-1:0] smp_idx,
  output logic [FW-1:0] m1_freq,
  output logic [IW-1:0] m1_idx,
  output logic          m1_have,
  output logic [FW-1:0] m2_freq,
  output logic [IW-1:0] m2_idx,
  output logic          m2_have
);

  logic [FW-1:0] f1_r, f1_nxt, f2_r, f2_nxt;
  logic [IW-1:0] i1_r, i1_nxt, i2_r, i2_nxt;
  logic          h1_r, h1_nxt, h2_r, h2_nxt;

  // Insert the new sample into the two-entry sorted list.
  always_comb begin
    f1_nxt = f1_r;
    i1_nxt = i1_r;
    h1_nxt = h1_r;
    f2_nxt = f2_r;
    i2_nxt = i2_r;
    h2_nxt = h2_r;
    if (clr) begin
      h1_nxt = 1'b0;
      h2_nxt = 1'b0;
    end else if (smp) begin
      if (!h1_r || smp_freq < f1_r) begin
        f2_nxt = f1_r;
        i2_nxt = i1_r;
        h2_nxt = h1_r;
        f1_nxt = smp_freq;
        i1_nxt = smp_idx;
        h1_nxt = 1'b1;
      end else if (!h2_r || smp_freq < f2_r) begin
        f2_nxt = smp_freq;
        i2_nxt = smp_idx;
        h2_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    f1_r <= f1_nxt;
    i1_r <= i1_nxt;
    h1_r <= h1_nxt;
    f2_r <= f2_nxt;
    i2_r <= i2_nxt;
    h2_r <= h2_nxt;
  end

  assign m1_freq = f1_r;
  assign m1_idx  = i1_r;
  assign m1_have = h1_r;
  assign m2_freq = f2_r;
  assign m2_idx  = i2_r;
  assign m2_have = h2_r;

endmodule

@@ rtl/core/huffman_code_builder_encoder_unit.sv @@
// Static Huffman encoder over a byte alphabet, driven by command beats.
// Input channel: in_command and in_symbol with in_valid/in_stall. A count
// beat adds one to the symbol's frequency, a build beat forms the tree and
// the code table, an encode beat returns one symbol's code, and a clear beat
// empties the frequency table. Every input beat yields exactly one result
// beat on out_* (code word, length, distinct symbol count, status).
// One beat is worked on at a time, and the input stalls until the block is
// back in idle. A count or encode beat issues its table read as it is taken,
// then passes through one update or lookup state and the result state, which
// loads the output register. A clear beat goes straight to the result state.
// Build runs a leaf pass over every symbol's frequency, then the merges of
// N leaves (a full scan of the used node slots per merge, one node read a
// cycle), then a code walk from each present symbol's leaf up to the root.
// Reset empties the frequency table, the total and the leaf count and marks
// the tree as not built; the node and code memories need no clearing.
// A stalled result holds in the output register; the next result then waits
// in the result state, with the input stalled, until the held one is taken.
module huffman_code_builder_encoder_unit
  import hcb_pkg::*;
#(
  parameter int SYMBOLS    = 256,
  parameter int NODE_SLOTS = 511,
  parameter int CODE_BITS  = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [7:0]                     in_symbol,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [CODE_BITS-1:0]           out_code_word,
  output logic [$clog2(CODE_BITS+1)-1:0] out_code_length,
  output logic [DISTINCT_W-1:0]          out_distinct_symbols,
  output logic [2:0]                     out_status
);

  localparam int FW  = COUNT_BITS;
  localparam int SW  = $clog2(SYMBOLS);
  localparam int SCW = $clog2(SYMBOLS + 1);
  localparam int NW  = $clog2(NODE_SLOTS);
  localparam int NCW = $clog2(NODE_SLOTS + 1);
  localparam int CLW = $clog2(CODE_BITS + 1);
  localparam int NDW = FW + NW + 3;
  localparam int CDW = 1 + CLW + CODE_BITS;
  localparam logic [FW-1:0] CNT_MAX = {FW{1'b1}};

  hcb_state_t state_r, state_nxt;

  logic [1:0]           cmd_r, cmd_nxt;
  logic [7:0]           sym_r, sym_nxt;
  logic                 built_r, built_nxt;
  logic [NCW-1:0]       leaf_cnt_r, leaf_cnt_nxt;
  logic [FW-1:0]        total_r, total_nxt;
  logic [SYMBOLS-1:0]   vld_r, vld_nxt;
  logic [SCW-1:0]       ctr_r, ctr_nxt;
  logic                 pend_r, pend_nxt;
  logic [SW-1:0]        pidx_r, pidx_nxt;
  logic [NCW-1:0]       nn_r, nn_nxt;
  logic [NCW-1:0]       iter_r, iter_nxt;
  logic [NCW-1:0]       scan_r, scan_nxt;
  logic                 spend_r, spend_nxt;
  logic [NW-1:0]        sidx_r, sidx_nxt;
  logic [NW-1:0]        cur_r, cur_nxt;
  logic [NCW-1:0]       wlen_r, wlen_nxt;
  logic [CODE_BITS-1:0] wcode_r, wcode_nxt;
  logic [CODE_BITS-1:0] res_code_r, res_code_nxt;
  logic [CLW-1:0]       res_len_r, res_len_nxt;
  logic [2:0]           res_st_r, res_st_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CODE_BITS-1:0] out_code_r, out_code_nxt;
  logic [CLW-1:0]       out_len_r, out_len_nxt;
  logic [DISTINCT_W-1:0] out_dist_r, out_dist_nxt;
  logic [2:0]           out_st_r, out_st_nxt;

  // Memories and their ports.
  logic [FW-1:0]  freq_mem [SYMBOLS];
  logic [NW-1:0]  leaf_mem [SYMBOLS];
  logic [NDW-1:0] node_mem [NODE_SLOTS];
  logic [CDW-1:0] code_mem [SYMBOLS];

  logic [SW-1:0]  sa_addr;
  logic           fw_en;
  logic [FW-1:0]  fw_data;
  logic [FW-1:0]  fr_data_r;
  logic           fr_vld_r;
  logic           lw_en;
  logic [SW-1:0]  lw_addr;
  logic [NW-1:0]  lw_data;
  logic [NW-1:0]  lr_data_r;
  logic           nw_en;
  logic [NW-1:0]  nw_addr;
  logic [NDW-1:0] nw_data;
  logic [NW-1:0]  nr_addr;
  logic [NDW-1:0] nr_data_r;
  logic           cw_en;
  logic [CDW-1:0] cw_data;
  logic [CDW-1:0] cr_data_r;

  // Decoded node read data.
  logic [FW-1:0] nd_freq;
  logic [NW-1:0] nd_parent;
  logic          nd_hp, nd_used, nd_one;
  assign {nd_freq, nd_parent, nd_hp, nd_used, nd_one} = nr_data_r;

  // Two-minimum tracker for the merge scan.
  logic          mn_clr, mn_smp;
  logic [FW-1:0] m1_freq, m2_freq;
  logic [NW-1:0] m1_idx, m2_idx;
  logic          m1_have, m2_have;

  hcb_min2 #(.FW(FW), .IW(NW)) u_min2 (
    .clk      (clk),
    .clr      (mn_clr),
    .smp      (mn_smp),
    .smp_freq (nd_freq),
    .smp_idx  (sidx_r),
    .m1_freq  (m1_freq),
    .m1_idx   (m1_idx),
    .m1_have  (m1_have),
    .m2_freq  (m2_freq),
    .m2_idx   (m2_idx),
    .m2_have  (m2_have)
  );

  logic          acc;
  logic [FW-1:0] eff_freq;
  logic          sym_oor;
  logic [NW-1:0] root_idx;
  logic          wl_ovf;
  logic          out_free;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign eff_freq = fr_vld_r ? fr_data_r : '0;
  assign sym_oor  = ({1'b0, sym_r} >= (DISTINCT_W)'(SYMBOLS));
  assign root_idx = NW'(nn_r - NCW'(1));
  assign wl_ovf   = (32'(wlen_r) > 32'(CODE_BITS));
  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_command)
            CMD_COUNT:  state_nxt = ST_CNT;
            CMD_BUILD:  state_nxt = ST_LEAF;
            CMD_ENCODE: state_nxt = ST_ENC;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_CNT, ST_ENC: state_nxt = ST_RESP;
      ST_LEAF: begin
        if (ctr_r == SCW'(SYMBOLS) && !pend_r) state_nxt = ST_MTOP;
      end
      ST_MTOP: begin
        if (iter_r == '0) state_nxt = ST_CODE;
        else if (nn_r < NCW'(NODE_SLOTS)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_r == nn_r && !spend_r) begin
          state_nxt = (m1_have && m2_have) ? ST_MW0 : ST_MTOP;
        end
      end
      ST_MW0: state_nxt = ST_MW1;
      ST_MW1: state_nxt = ST_MW2;
      ST_MW2: state_nxt = ST_MTOP;
      ST_CODE: begin
        state_nxt = (ctr_r == SCW'(SYMBOLS)) ? ST_RESP : ST_CFET;
      end
      ST_CFET: begin
        state_nxt = (fr_vld_r && fr_data_r != '0) ? ST_WREQ : ST_CODE;
      end
      ST_WREQ: state_nxt = (cur_r == root_idx) ? ST_CODE : ST_WDAT;
      ST_WDAT: state_nxt = nd_hp ? ST_WREQ : ST_CODE;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cmd_nxt      = cmd_r;
    sym_nxt      = sym_r;
    built_nxt    = built_r;
    leaf_cnt_nxt = leaf_cnt_r;
    total_nxt    = total_r;
    vld_nxt      = vld_r;
    ctr_nxt      = ctr_r;
    pend_nxt     = pend_r;
    pidx_nxt     = pidx_r;
    nn_nxt       = nn_r;
    iter_nxt     = iter_r;
    scan_nxt     = scan_r;
    spend_nxt    = spend_r;
    sidx_nxt     = sidx_r;
    cur_nxt      = cur_r;
    wlen_nxt     = wlen_r;
    wcode_nxt    = wcode_r;
    res_code_nxt = res_code_r;
    res_len_nxt  = res_len_r;
    res_st_nxt   = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_code_nxt = out_code_r;
    out_len_nxt  = out_len_r;
    out_dist_nxt = out_dist_r;
    out_st_nxt   = out_st_r;
    sa_addr      = ctr_r[SW-1:0];
    fw_en        = 1'b0;
    fw_data      = eff_freq + FW'(1);
    lw_en        = 1'b0;
    lw_addr      = pidx_r;
    lw_data      = NW'(nn_r);
    nw_en        = 1'b0;
    nw_addr      = NW'(nn_r);
    nw_data      = {eff_freq, {NW{1'b0}}, 3'b000};
    nr_addr      = NW'(scan_r);
    cw_en        = 1'b0;
    cw_data      = {wl_ovf, wl_ovf ? {CLW{1'b0}} : CLW'(wlen_r),
                    wl_ovf ? {CODE_BITS{1'b0}} : wcode_r};
    mn_clr       = 1'b0;
    mn_smp       = 1'b0;
    case (state_r)
      // Take a command and start its table reads.
      ST_IDLE: begin
        sa_addr = in_symbol[SW-1:0];
        if (acc) begin
          cmd_nxt      = in_command;
          sym_nxt      = in_symbol;
          res_code_nxt = '0;
          res_len_nxt  = '0;
          res_st_nxt   = STS_OK;
          case (in_command)
            CMD_COUNT: built_nxt = 1'b0;
            CMD_BUILD: begin
              ctr_nxt  = '0;
              pend_nxt = 1'b0;
              nn_nxt   = '0;
            end
            CMD_ENCODE: ;
            default: begin
              vld_nxt      = '0;
              total_nxt    = '0;
              leaf_cnt_nxt = '0;
              built_nxt    = 1'b0;
            end
          endcase
        end
      end
      // Frequency read-modify-write.
      ST_CNT: begin
        sa_addr = sym_r[SW-1:0];
        if (sym_oor) begin
          res_st_nxt = STS_ABSENT;
        end else if (total_r >= CNT_MAX) begin
          res_st_nxt = STS_SATURATED;
        end else begin
          fw_en = 1'b1;
          vld_nxt[sym_r[SW-1:0]] = 1'b1;
          total_nxt = total_r + FW'(1);
        end
      end
      // Code lookup.
      ST_ENC: begin
        if (!built_r) begin
          res_st_nxt = STS_NOT_BUILT;
        end else if (sym_oor || eff_freq == '0) begin
          res_st_nxt = STS_ABSENT;
        end else if (cr_data_r[CDW-1]) begin
          res_st_nxt = STS_TOO_LONG;
        end else begin
          res_code_nxt = cr_data_r[CODE_BITS-1:0];
          res_len_nxt  = cr_data_r[CODE_BITS +: CLW];
        end
      end
      // Leaf pass: one frequency read a cycle, leaves packed in symbol order.
      ST_LEAF: begin
        pend_nxt = 1'b0;
        if (ctr_r < SCW'(SYMBOLS)) begin
          pend_nxt = 1'b1;
          pidx_nxt = ctr_r[SW-1:0];
          ctr_nxt  = ctr_r + SCW'(1);
        end
        if (pend_r && eff_freq != '0 && nn_r < NCW'(NODE_SLOTS)) begin
          nw_en  = 1'b1;
          lw_en  = 1'b1;
          nn_nxt = nn_r + NCW'(1);
        end
        if (ctr_r == SCW'(SYMBOLS) && !pend_r) begin
          leaf_cnt_nxt = nn_r;
          iter_nxt     = (nn_r > NCW'(1)) ? nn_r - NCW'(1) : '0;
        end
      end
      // One merge per round; skipped once the node memory is full.
      ST_MTOP: begin
        ctr_nxt = '0;
        if (iter_r != '0) begin
          if (nn_r < NCW'(NODE_SLOTS)) begin
            scan_nxt  = '0;
            spend_nxt = 1'b0;
            mn_clr    = 1'b1;
          end else begin
            iter_nxt = iter_r - NCW'(1);
          end
        end
      end
      // Scan every node for the two lowest unused frequencies.
      ST_SCAN: begin
        spend_nxt = 1'b0;
        if (scan_r < nn_r) begin
          spend_nxt = 1'b1;
          sidx_nxt  = NW'(scan_r);
          scan_nxt  = scan_r + NCW'(1);
        end
        mn_smp = spend_r && !nd_used;
        if (scan_r == nn_r && !spend_r && !(m1_have && m2_have)) begin
          iter_nxt = iter_r - NCW'(1);
        end
      end
      // New parent node, then the two children.
      ST_MW0: begin
        nw_en   = 1'b1;
        nw_data = {m1_freq + m2_freq, {NW{1'b0}}, 3'b000};
      end
      ST_MW1: begin
        nw_en   = 1'b1;
        nw_addr = m1_idx;
        nw_data = {m1_freq, NW'(nn_r), 3'b110};
      end
      ST_MW2: begin
        nw_en    = 1'b1;
        nw_addr  = m2_idx;
        nw_data  = {m2_freq, NW'(nn_r), 3'b111};
        nn_nxt   = nn_r + NCW'(1);
        iter_nxt = iter_r - NCW'(1);
      end
      // Code pass: fetch the symbol's frequency and leaf index.
      ST_CODE: begin
        if (ctr_r == SCW'(SYMBOLS)) begin
          built_nxt = 1'b1;
        end
      end
      ST_CFET: begin
        if (fr_vld_r && fr_data_r != '0) begin
          cur_nxt   = lr_data_r;
          wlen_nxt  = '0;
          wcode_nxt = '0;
        end else begin
          ctr_nxt = ctr_r + SCW'(1);
        end
      end
      // Walk from the leaf toward the root, one level per pass through the request and data states.
      ST_WREQ: begin
        nr_addr = cur_r;
        if (cur_r == root_idx) begin
          cw_en   = 1'b1;
          ctr_nxt = ctr_r + SCW'(1);
        end
      end
      ST_WDAT: begin
        if (nd_hp) begin
          if (nd_one && 32'(wlen_r) < 32'(CODE_BITS)) begin
            wcode_nxt = wcode_r | (CODE_BITS'(1) << wlen_r);
          end
          wlen_nxt = wlen_r + NCW'(1);
          cur_nxt  = nd_parent;
        end else begin
          cw_en   = 1'b1;
          ctr_nxt = ctr_r + SCW'(1);
        end
      end
      // Load the result register once it is free.
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = res_code_r;
          out_len_nxt   = res_len_r;
          out_dist_nxt  = DISTINCT_W'(leaf_cnt_r);
          out_st_nxt    = res_st_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      built_r     <= 1'b0;
      leaf_cnt_r  <= '0;
      total_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      spend_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      leaf_cnt_r  <= leaf_cnt_nxt;
      total_r     <= total_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      spend_r     <= spend_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    sym_r      <= sym_nxt;
    ctr_r      <= ctr_nxt;
    pidx_r     <= pidx_nxt;
    nn_r       <= nn_nxt;
    iter_r     <= iter_nxt;
    scan_r     <= scan_nxt;
    sidx_r     <= sidx_nxt;
    cur_r      <= cur_nxt;
    wlen_r     <= wlen_nxt;
    wcode_r    <= wcode_nxt;
    res_code_r <= res_code_nxt;
    res_len_r  <= res_len_nxt;
    res_st_r   <= res_st_nxt;
    out_code_r <= out_code_nxt;
    out_len_r  <= out_len_nxt;
    out_dist_r <= out_dist_nxt;
    out_st_r   <= out_st_nxt;
  end

  // Symbol-indexed memories share one read address.
  always_ff @(posedge clk) begin
    if (fw_en) freq_mem[sa_addr] <= fw_data;
    if (lw_en) leaf_mem[lw_addr] <= lw_data;
    if (cw_en) code_mem[ctr_r[SW-1:0]] <= cw_data;
    fr_data_r <= freq_mem[sa_addr];
    fr_vld_r  <= vld_nxt[sa_addr] & vld_r[sa_addr];
    lr_data_r <= leaf_mem[sa_addr];
    cr_data_r <= code_mem[sa_addr];
  end

  // Node memory.
  always_ff @(posedge clk) begin
    if (nw_en) node_mem[nw_addr] <= nw_data;
    nr_data_r <= node_mem[nr_addr];
  end

  assign out_valid            = out_valid_r;
  assign out_code_word        = out_code_r;
  assign out_code_length      = out_len_r;
  assign out_distinct_symbols = out_dist_r;
  assign out_status           = out_st_r;

`ifndef NO_ASSERTIONS
  // The total never passes the saturation point.
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_MAX)
    else $error("total count beyond saturation");

  // A clear beat empties the leaf count and drops the built flag.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_command == CMD_CLEAR) |=> (leaf_cnt_r == '0 && !built_r))
    else $error("clear did not reset tree state");

  // The tree is only marked built at the end of a build.
  a_built_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> ($past(state_r) == ST_CODE && cmd_r == CMD_BUILD))
    else $error("built flag set outside a build");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_valid_r && out_stall) |=> state_r == ST_RESP)
    else $error("result register overwritten");
`endif

endmodule

@@ tb/huffman_code_builder_encoder_unit_test.sv @@
`timescale 1ns / 1ps

module huffman_code_builder_encoder_unit_test;
  import hcb_pkg::*;

  localparam int ALPHABET   = 256;
  localparam int SLOTS      = 511;
  localparam int MAX_CODE   = 32;
  localparam int FREQ_BITS  = 24;

  // One result beat as the block reports it.
  typedef struct {
    logic [31:0] code_word;
    logic [5:0]  code_length;
    logic [8:0]  distinct;
    logic [2:0]  status;
  } code_result_t;

  // Tracks the encoder's tables and holds the results still owed by the block.
  class huffman_scoreboard;
    longint unsigned sym_count[ALPHABET];
    longint unsigned sum_count;
    longint unsigned node_weight[SLOTS];
    int              node_parent[SLOTS];
    bit              node_linked[SLOTS];
    bit              node_taken[SLOTS];
    bit              node_is_one[SLOTS];
    logic [31:0]     code_of[ALPHABET];
    int              length_of[ALPHABET];
    bit              too_deep[ALPHABET];
    int              leaf_index[ALPHABET];
    int              leaves;
    bit              tree_ready;
    code_result_t    owed[$];
    int              errors;

    function new();
      foreach (sym_count[s]) begin
        sym_count[s] = 0;
        code_of[s] = '0;
        length_of[s] = 0;
        too_deep[s] = 0;
        leaf_index[s] = 0;
      end
      sum_count = 0;
      leaves = 0;
      tree_ready = 0;
      errors = 0;
    endfunction

    function int seen_symbols();
      int n;
      n = 0;
      foreach (sym_count[s]) if (sym_count[s] != 0) n++;
      return n;
    endfunction

    // Lowest-weight free node below limit; ties go to the lowest index.
    function int lightest(int limit, int skip);
      int found;
      longint unsigned best;
      found = -1;
      best = 0;
      for (int i = 0; i < limit; i++) begin
        if (i != skip && !node_taken[i] && (found < 0 || node_weight[i] < best)) begin
          found = i;
          best = node_weight[i];
        end
      end
      return found;
    endfunction

    function void build_codes();
      int n, top, root, a, b, node, depth;
      logic [31:0] bits;
      n = 0;
      // Leaves in symbol order.
      for (int s = 0; s < ALPHABET; s++) begin
        code_of[s] = '0;
        length_of[s] = 0;
        too_deep[s] = 0;
        if (sym_count[s] != 0) begin
          node_weight[n] = sym_count[s];
          node_linked[n] = 0;
          node_parent[n] = 0;
          node_taken[n] = 0;
          node_is_one[n] = 0;
          leaf_index[s] = n;
          n++;
        end
      end
      leaves = n;
      top = n;
      // Merge the two lightest free nodes until one remains.
      for (int r = n; r > 1; r--) begin
        a = lightest(top, -1);
        b = lightest(top, a);
        if (a >= 0 && b >= 0 && top < SLOTS) begin
          node_weight[top] = node_weight[a] + node_weight[b];
          node_linked[top] = 0;
          node_parent[top] = 0;
          node_taken[top] = 0;
          node_is_one[top] = 0;
          node_taken[a] = 1;
          node_linked[a] = 1;
          node_parent[a] = top;
          node_is_one[a] = 0;
          node_taken[b] = 1;
          node_linked[b] = 1;
          node_parent[b] = top;
          node_is_one[b] = 1;
          top++;
        end
      end
      root = (top > 0) ? top - 1 : 0;
      // Walk each leaf up to the root; the root-side bit lands highest.
      for (int s = 0; s < ALPHABET; s++) begin
        if (sym_count[s] != 0) begin
          node = leaf_index[s];
          depth = 0;
          bits = '0;
          while (node != root && node_linked[node] && depth < SLOTS) begin
            if (node_is_one[node] && depth < MAX_CODE) bits[depth] = 1'b1;
            depth++;
            node = node_parent[node];
          end
          if (depth > MAX_CODE) too_deep[s] = 1;
          else begin
            code_of[s] = bits;
            length_of[s] = depth;
          end
        end
      end
      tree_ready = 1;
    endfunction

    // Works out the result of one accepted input beat.
    function void note_input(logic [1:0] cmd, logic [7:0] sym);
      code_result_t res;
      res.code_word = '0;
      res.code_length = '0;
      res.status = STS_OK;
      case (cmd)
        CMD_COUNT: begin
          tree_ready = 0;
          if (sum_count >= (64'd1 << FREQ_BITS) - 1) res.status = STS_SATURATED;
          else begin
            sym_count[sym]++;
            sum_count++;
          end
        end
        CMD_BUILD: build_codes();
        CMD_ENCODE: begin
          if (!tree_ready) res.status = STS_NOT_BUILT;
          else if (sym_count[sym] == 0) res.status = STS_ABSENT;
          else if (too_deep[sym]) res.status = STS_TOO_LONG;
          else begin
            res.code_word = code_of[sym];
            res.code_length = 6'(length_of[sym]);
          end
        end
        default: begin
          foreach (sym_count[s]) sym_count[s] = 0;
          sum_count = 0;
          leaves = 0;
          tree_ready = 0;
        end
      endcase
      res.distinct = 9'(leaves);
      owed.push_back(res);
    endfunction

    // Compares one result beat with the oldest owed result.
    function void check_result(code_result_t got);
      code_result_t want;
      if (owed.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.code_word !== want.code_word) begin
        $error("code_word: expected %h, got %h", want.code_word, got.code_word);
        errors++;
      end
      if (got.code_length !== want.code_length) begin
        $error("code_length: expected %0d, got %0d", want.code_length, got.code_length);
        errors++;
      end
      if (got.distinct !== want.distinct) begin
        $error("distinct_symbols: expected %0d, got %0d", want.distinct, got.distinct);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [7:0]  in_symbol;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_code_word;
  logic [5:0]  out_code_length;
  logic [8:0]  out_distinct_symbols;
  logic [2:0]  out_status;

  huffman_scoreboard board;
  int  burst_left;
  int  beats_sent;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  stall_phase = 0;

  huffman_code_builder_encoder_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_symbol           (in_symbol),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_code_word       (out_code_word),
    .out_code_length     (out_code_length),
    .out_distinct_symbols(out_distinct_symbols),
    .out_status          (out_status)
  );

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver stalls: a pattern that steps through four modes, plus one long hold-off.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_sent > 650) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      case ((stall_phase / 64) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3, 0) == 0);
        2: out_stall <= ($urandom_range(3, 0) != 0);
        default: out_stall <= ($urandom_range(1, 0) != 0);
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    code_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.code_word = out_code_word;
      got.code_length = out_code_length;
      got.distinct = out_distinct_symbols;
      got.status = out_status;
      board.check_result(got);
    end
  end

  // Offers one input beat, opening a new burst after a random gap when one runs out.
  task automatic send_beat(logic [1:0] cmd, logic [7:0] sym);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(20, 1);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_symbol <= sym;
    do @(posedge clk); while (in_stall);
    board.note_input(cmd, sym);
    burst_left--;
    beats_sent++;
  endtask

  // One well-formed run: optional clear, counts over a small alphabet, build, encodes.
  task automatic code_session();
    logic [7:0] pool[];
    int kinds, counts;
    if (board.seen_symbols() > 30 || $urandom_range(5, 0) != 0)
      send_beat(CMD_CLEAR, 8'($urandom));
    kinds = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 11) : $urandom_range(8, 1);
    pool = new[kinds];
    foreach (pool[i]) pool[i] = 8'($urandom);
    counts = $urandom_range(3 * kinds + 4, kinds);
    for (int i = 0; i < counts; i++)
      // Skew towards the front of the pool so that trees come out lopsided.
      send_beat(CMD_COUNT, pool[$urandom_range($urandom_range(kinds - 1, 0), 0)]);
    if ($urandom_range(7, 0) == 0) send_beat(CMD_ENCODE, pool[0]);
    send_beat(CMD_BUILD, 8'($urandom));
    repeat ($urandom_range(14, 4)) begin
      if ($urandom_range(4, 0) == 0) send_beat(CMD_ENCODE, 8'($urandom));
      else send_beat(CMD_ENCODE, pool[$urandom_range(kinds - 1, 0)]);
    end
    // Noise: a stray count or clear after the build hides the codes again.
    if ($urandom_range(6, 0) == 0) begin
      send_beat(($urandom_range(1, 0) != 0) ? CMD_COUNT : CMD_CLEAR, pool[0]);
      send_beat(CMD_ENCODE, pool[0]);
    end
  endtask

  initial begin
    int order[ALPHABET];
    int j, tmp;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_COUNT;
    in_symbol = '0;
    burst_left = 0;
    beats_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: before build, empty build, single symbol, two symbols, stale codes.
    send_beat(CMD_ENCODE, 8'd0);
    send_beat(CMD_BUILD, 8'd0);
    send_beat(CMD_ENCODE, 8'd0);
    send_beat(CMD_COUNT, 8'd0);
    send_beat(CMD_BUILD, 8'hff);
    send_beat(CMD_ENCODE, 8'd0);
    send_beat(CMD_ENCODE, 8'hff);
    send_beat(CMD_COUNT, 8'hff);
    send_beat(CMD_COUNT, 8'hff);
    send_beat(CMD_BUILD, 8'd0);
    send_beat(CMD_ENCODE, 8'd0);
    send_beat(CMD_ENCODE, 8'hff);
    send_beat(CMD_ENCODE, 8'h55);
    send_beat(CMD_COUNT, 8'haa);
    send_beat(CMD_ENCODE, 8'hff);
    send_beat(CMD_BUILD, 8'd0);
    send_beat(CMD_ENCODE, 8'haa);
    send_beat(CMD_CLEAR, 8'hff);
    send_beat(CMD_ENCODE, 8'haa);
    send_beat(CMD_BUILD, 8'd0);
    send_beat(CMD_ENCODE, 8'haa);

    // Full alphabet once, in shuffled order with some repeats.
    foreach (order[i]) order[i] = i;
    for (int i = ALPHABET - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_beat(CMD_CLEAR, 8'd0);
    foreach (order[i]) send_beat(CMD_COUNT, 8'(order[i]));
    repeat (60) send_beat(CMD_COUNT, 8'($urandom_range(15, 0)));
    send_beat(CMD_BUILD, 8'd0);
    repeat (30) send_beat(CMD_ENCODE, 8'($urandom));

    // Random sessions; the receiver holds off once partway through.
    while (beats_sent < 1050) begin
      code_session();
    end
    in_valid <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
